[rtl/psmc_pkg.sv]
// ----------------------------------------------------------------------------
// psmc_pkg
// Shared types and constants for the ps2 mouse cursor tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package psmc_pkg;

    localparam int BYTE_W  = 8;
    localparam int COORD_W = 12;
    localparam int SIZE_W  = 13;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [SIZE_W-1:0]  SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [SIZE_W-1:0]  SCREEN_HEIGHT_RST = 13'd768;
    localparam logic [COORD_W-1:0] POS_X_RST = 12'd512;
    localparam logic [COORD_W-1:0] POS_Y_RST = 12'd384;

    localparam logic [BYTE_W-1:0] HDR_SYNC_MASK  = 8'h08;
    localparam logic [BYTE_W-1:0] HDR_LEFT_MASK  = 8'h01;
    localparam logic [BYTE_W-1:0] HDR_RIGHT_MASK = 8'h02;

    typedef struct packed {
        logic              last;
        logic              left_button;
        logic              right_button;
        logic [BYTE_W-1:0] dx;
        logic [BYTE_W-1:0] dy;
    } pkt_t;

endpackage

`default_nettype wire

[rtl/ps2_mouse_cursor_tracker.sv]
// ----------------------------------------------------------------------------
// ps2_mouse_cursor_tracker
// Frames ps2 mouse bytes into packets and tracks a clamped cursor position.
// ----------------------------------------------------------------------------
//  channel   signals                           direction
//  input     in_valid, in_ready, rx_byte       byte from mouse
//  output    out_valid, out_ready, cursor_x,   one per packet
//            cursor_y, old_x, old_y,
//            left_button, right_button
//  config    cfg_we, cfg_index, cfg_data       write only
//
//  one byte per cycle unless a stalled result holds the third byte; a byte is
//  held in the input register, then the framer and the add/clamp logic load the result register on the third byte
//  reset: cursor at 512,384 on a 1024x768 screen, awaiting a header byte
//  a stalled result blocks only the third byte of the next packet
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_cursor_tracker
    import psmc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [BYTE_W-1:0]    rx_byte,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [COORD_W-1:0]        cursor_x,
    output logic [COORD_W-1:0]        cursor_y,
    output logic [COORD_W-1:0]        old_x,
    output logic [COORD_W-1:0]        old_y,
    output logic                      left_button,
    output logic                      right_button,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data
);

    logic               stage_valid_reg;
    logic               stage_valid_next;
    logic [BYTE_W-1:0]  stage_byte_reg;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [COORD_W-1:0] cursor_x_reg;
    logic [COORD_W-1:0] cursor_y_reg;
    logic [COORD_W-1:0] old_x_reg;
    logic [COORD_W-1:0] old_y_reg;
    logic               left_reg;
    logic               right_reg;
    logic               stage_go;
    logic               load_result;
    logic               in_fire;
    pkt_t               pkt;
    logic [COORD_W-1:0] new_x;
    logic [COORD_W-1:0] new_y;
    logic [COORD_W-1:0] prev_x;
    logic [COORD_W-1:0] prev_y;

    assign stage_go    = stage_valid_reg && (!pkt.last || !out_valid_reg || out_ready);
    assign load_result = stage_go && pkt.last;
    assign in_ready    = !stage_valid_reg || stage_go;
    assign in_fire     = in_valid && in_ready;

    assign stage_valid_next = in_fire ? 1'b1 : (stage_go ? 1'b0 : stage_valid_reg);
    assign out_valid_next   = load_result ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    psmc_framer u_framer (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (stage_go),
        .rx_data (stage_byte_reg),
        .pkt     (pkt)
    );

    psmc_cursor u_cursor (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .update    (load_result),
        .pkt       (pkt),
        .new_x     (new_x),
        .new_y     (new_y),
        .prev_x    (prev_x),
        .prev_y    (prev_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            stage_byte_reg <= rx_byte;
        if (load_result)
        begin
            cursor_x_reg <= new_x;
            cursor_y_reg <= new_y;
            old_x_reg    <= prev_x;
            old_y_reg    <= prev_y;
            left_reg     <= pkt.left_button;
            right_reg    <= pkt.right_button;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cursor_x     = cursor_x_reg;
    assign cursor_y     = cursor_y_reg;
    assign old_x        = old_x_reg;
    assign old_y        = old_y_reg;
    assign left_button  = left_reg;
    assign right_button = right_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !load_result)
        else $error("result register overwritten before transfer");

    a_stall_holds_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && !stage_go) |=> (stage_valid_reg && $stable(stage_byte_reg)))
        else $error("stalled byte lost from input register");

endmodule

`default_nettype wire

[rtl/psmc_framer.sv]
// ----------------------------------------------------------------------------
// psmc_framer
// Frames the byte stream into 3-byte packets and drops unsynced headers.
// ----------------------------------------------------------------------------
`default_nettype none

module psmc_framer
    import psmc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [BYTE_W-1:0] rx_data,
    output pkt_t                   pkt
);

    typedef enum logic [2:0] {
        PH_HEAD  = 3'b001,
        PH_XMOVE = 3'b010,
        PH_YMOVE = 3'b100
    } phase_t;

    phase_t            phase_reg;
    phase_t            phase_next;
    logic [BYTE_W-1:0] header_reg;
    logic [BYTE_W-1:0] header_next;
    logic [BYTE_W-1:0] xmove_reg;
    logic [BYTE_W-1:0] xmove_next;

    always_comb
    begin
        phase_next  = phase_reg;
        header_next = header_reg;
        xmove_next  = xmove_reg;
        if (step)
        begin
            case (phase_reg)
                PH_XMOVE:
                begin
                    xmove_next = rx_data;
                    phase_next = PH_YMOVE;
                end
                PH_YMOVE:
                begin
                    phase_next = PH_HEAD;
                end
                default:
                begin
                    if ((rx_data & HDR_SYNC_MASK) != '0)
                    begin
                        header_next = rx_data;
                        phase_next  = PH_XMOVE;
                    end
                    else
                    begin
                        phase_next = PH_HEAD;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD;
            header_reg <= '0;
            xmove_reg  <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            header_reg <= header_next;
            xmove_reg  <= xmove_next;
        end
    end

    assign pkt.last         = (phase_reg == PH_YMOVE);
    assign pkt.left_button  = (header_reg & HDR_LEFT_MASK) != '0;
    assign pkt.right_button = (header_reg & HDR_RIGHT_MASK) != '0;
    assign pkt.dx           = xmove_reg;
    assign pkt.dy           = rx_data;

    a_xmove_then_ymove: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_XMOVE) |=> (phase_reg == PH_YMOVE))
        else $error("framer did not advance to the y move byte");

    a_packet_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_YMOVE) |=> (phase_reg == PH_HEAD))
        else $error("framer did not return to header after a packet");

endmodule

`default_nettype wire

[rtl/psmc_cursor.sv]
// ----------------------------------------------------------------------------
// psmc_cursor
// Screen size registers and cursor position update with clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module psmc_cursor
    import psmc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data,
    input  wire logic                 update,
    input  wire pkt_t                 pkt,
    output logic [COORD_W-1:0]        new_x,
    output logic [COORD_W-1:0]        new_y,
    output logic [COORD_W-1:0]        prev_x,
    output logic [COORD_W-1:0]        prev_y
);

    localparam int SUM_W = COORD_W + 2;
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(1 << COORD_W);

    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [COORD_W-1:0] pos_x_reg;
    logic [COORD_W-1:0] pos_x_next;
    logic [COORD_W-1:0] pos_y_reg;
    logic [COORD_W-1:0] pos_y_next;
    logic [SIZE_W-1:0]  lim_x;
    logic [SIZE_W-1:0]  lim_y;
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;

    function automatic logic [SIZE_W-1:0] size_limit(input logic [SIZE_W-1:0] size);
        logic [SIZE_W-1:0] lim;
        if (size == '0)
            lim = SIZE_W'(1);
        else if (size > SIZE_MAX)
            lim = SIZE_MAX;
        else
            lim = size;
        return lim;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_coord(input logic [SUM_W-1:0] v,
                                                       input logic [SIZE_W-1:0] lim);
        logic [SIZE_W-1:0]  top;
        logic [COORD_W-1:0] res;
        top = lim - SIZE_W'(1);
        if (v[SUM_W-1])
            res = '0;
        else if (v[SIZE_W-1:0] >= lim)
            res = top[COORD_W-1:0];
        else
            res = v[COORD_W-1:0];
        return res;
    endfunction

    assign lim_x = size_limit(width_reg);
    assign lim_y = size_limit(height_reg);

    // screen down is positive, so the y move is subtracted
    assign sum_x = {2'b00, pos_x_reg} + {{(SUM_W-BYTE_W){pkt.dx[BYTE_W-1]}}, pkt.dx};
    assign sum_y = {2'b00, pos_y_reg} - {{(SUM_W-BYTE_W){pkt.dy[BYTE_W-1]}}, pkt.dy};

    assign new_x  = clamp_coord(sum_x, lim_x);
    assign new_y  = clamp_coord(sum_y, lim_y);
    assign prev_x = pos_x_reg;
    assign prev_y = pos_y_reg;

    assign pos_x_next = update ? new_x : pos_x_reg;
    assign pos_y_next = update ? new_y : pos_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
            pos_x_reg  <= POS_X_RST;
            pos_y_reg  <= POS_Y_RST;
        end
        else
        begin
            if (cfg_we && cfg_index == REG_SCREEN_WIDTH)
                width_reg <= cfg_data;
            if (cfg_we && cfg_index == REG_SCREEN_HEIGHT)
                height_reg <= cfg_data;
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
        end
    end

    a_x_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        update |=> ({1'b0, pos_x_reg} < $past(lim_x)))
        else $error("cursor x left the screen");

    a_y_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
        update |=> ({1'b0, pos_y_reg} < $past(lim_y)))
        else $error("cursor y left the screen");

endmodule

`default_nettype wire

[tb/tb_ps2_mouse_cursor_tracker.sv]
// ----------------------------------------------------------------------------
// tb_ps2_mouse_cursor_tracker
// Self-checking bench for the ps2 mouse cursor tracker. Mouse bytes go in
// through the valid/ready input with random gaps, and results are drained
// with random stalls. A local tracker model frames each accepted byte and
// queues the expected cursor report for every completed packet. Screen sizes
// are rewritten between phases while the block is idle, including zero,
// oversize and unused register indexes.
// ----------------------------------------------------------------------------
module tb_ps2_mouse_cursor_tracker
    import psmc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 4;
    localparam int PRINT_CAP    = 40;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_X_MOVE = 2'd1;
    localparam logic [1:0] PH_Y_MOVE = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] cx;
        logic [COORD_W-1:0] cy;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic               left;
        logic               right;
    } cursor_rec_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [COORD_W-1:0]   cursor_x;
    logic [COORD_W-1:0]   cursor_y;
    logic [COORD_W-1:0]   old_x;
    logic [COORD_W-1:0]   old_y;
    logic                 left_button;
    logic                 right_button;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data = '0;

    // tracker model state
    logic [1:0]         trk_phase  = PH_HEADER;
    logic [BYTE_W-1:0]  trk_header = '0;
    logic [BYTE_W-1:0]  trk_dx     = '0;
    logic [COORD_W-1:0] trk_x      = POS_X_RST;
    logic [COORD_W-1:0] trk_y      = POS_Y_RST;
    logic [SIZE_W-1:0]  trk_width  = SCREEN_WIDTH_RST;
    logic [SIZE_W-1:0]  trk_height = SCREEN_HEIGHT_RST;

    cursor_rec_t expected_cursors[$];
    int          mismatch_count = 0;
    int          cycle_count = 0;
    bit          steady_flow = 1'b0;

    ps2_mouse_cursor_tracker u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .cursor_x     (cursor_x),
        .cursor_y     (cursor_y),
        .old_x        (old_x),
        .old_y        (old_y),
        .left_button  (left_button),
        .right_button (right_button),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [COORD_W-1:0] clamp_to_screen(input int v,
                                                           input logic [SIZE_W-1:0] size);
        int lim;
        lim = (size == 0) ? 1 : (size > 4096) ? 4096 : int'(size);
        if (v < 0)
            return '0;
        if (v >= lim)
            return COORD_W'(lim - 1);
        return COORD_W'(v);
    endfunction

    task automatic track_byte(input logic [BYTE_W-1:0] b);
        cursor_rec_t rec;
        int          nx;
        int          ny;
        if (trk_phase == PH_X_MOVE)
        begin
            trk_dx    = b;
            trk_phase = PH_Y_MOVE;
        end
        else if (trk_phase == PH_Y_MOVE)
        begin
            trk_phase = PH_HEADER;
            nx        = int'(trk_x) + int'($signed(trk_dx));
            ny        = int'(trk_y) - int'($signed(b));
            rec.ox    = trk_x;
            rec.oy    = trk_y;
            trk_x     = clamp_to_screen(nx, trk_width);
            trk_y     = clamp_to_screen(ny, trk_height);
            rec.cx    = trk_x;
            rec.cy    = trk_y;
            rec.left  = |(trk_header & HDR_LEFT_MASK);
            rec.right = |(trk_header & HDR_RIGHT_MASK);
            expected_cursors.push_back(rec);
        end
        else if ((b & HDR_SYNC_MASK) != 0)
        begin
            trk_header = b;
            trk_phase  = PH_X_MOVE;
        end
        else
        begin
            trk_phase = PH_HEADER;
        end
    endtask

    task automatic log_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("[%0t] mismatch %s: got %0d expected %0d", $time, what, got, want);
    endtask

    // byte transfers feed the model, result transfers are checked
    always @(posedge clk)
    begin
        cursor_rec_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                track_byte(rx_byte);
            if (out_valid && out_ready)
            begin
                if (expected_cursors.size() == 0)
                begin
                    log_mismatch("unexpected result, cursor_x", cursor_x, -1);
                end
                else
                begin
                    want = expected_cursors.pop_front();
                    if (cursor_x !== want.cx)
                        log_mismatch("cursor_x", cursor_x, want.cx);
                    if (cursor_y !== want.cy)
                        log_mismatch("cursor_y", cursor_y, want.cy);
                    if (old_x !== want.ox)
                        log_mismatch("old_x", old_x, want.ox);
                    if (old_y !== want.oy)
                        log_mismatch("old_y", old_y, want.oy);
                    if (left_button !== want.left)
                        log_mismatch("left_button", left_button, want.left);
                    if (right_button !== want.right)
                        log_mismatch("right_button", right_button, want.right);
                end
            end
        end
    end

    // result side stalls
    initial
    begin
        int stall;
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 13);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 13);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_packet(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] dx,
                               input logic [BYTE_W-1:0] dy);
        send_byte(hdr);
        send_byte(dx);
        send_byte(dy);
    endtask

    task automatic settle_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_cursors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SCREEN_WIDTH)
            trk_width = data;
        else if (idx == REG_SCREEN_HEIGHT)
            trk_height = data;
        @(posedge clk);
    endtask

    function automatic logic [BYTE_W-1:0] pick_move();
        case ($urandom_range(0, 7))
            0: return 8'h7F;
            1: return 8'h80;
            2: return 8'hFF;
            3: return 8'h00;
            default: return BYTE_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(0, 3))
            0: return SIZE_W'($urandom_range(0, 8191));
            1: return SIZE_W'($urandom_range(1, 40));
            2: return SIZE_W'($urandom_range(4090, 4100));
            default: return SIZE_W'($urandom_range(100, 1500));
        endcase
    endfunction

    // reset screen, button combos, move extremes and dropped unsynced bytes
    task automatic test_reset_packets();
        send_byte(8'h00);
        send_byte(8'hF7);
        send_packet(8'h08, 8'h00, 8'h00);
        send_packet(8'h09, 8'h7F, 8'h80);
        send_packet(8'h0A, 8'h80, 8'h7F);
        send_packet(8'hFF, 8'hFF, 8'hFF);
        settle_idle();
    endtask

    // zero and oversize screens, then shrink below the cursor
    task automatic test_screen_extremes();
        write_reg(REG_SCREEN_WIDTH, 13'd0);
        write_reg(REG_SCREEN_HEIGHT, 13'd0);
        send_packet(8'h0B, 8'h7F, 8'h80);
        settle_idle();
        write_reg(REG_SCREEN_WIDTH, 13'h1FFF);
        write_reg(REG_SCREEN_HEIGHT, 13'd4096);
        send_packet(8'h08, 8'h7F, 8'h80);
        settle_idle();
        write_reg(REG_SCREEN_WIDTH, 13'd8);
        write_reg(REG_SCREEN_HEIGHT, 13'd8);
        send_packet(8'h08, 8'h00, 8'h00);
        settle_idle();
    endtask

    // writes to indexes past the register list change nothing
    task automatic test_spare_indexes();
        write_reg(REG_SPARE_A, 13'd1);
        write_reg(REG_SPARE_B, 13'h1FFF);
        send_packet(8'h08, 8'h7F, 8'h80);
        settle_idle();
    endtask

    task automatic test_random_traffic();
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
        int                sent;
        int                pick;
        for (int p = 0; p < 12; p++)
        begin
            case (p)
                0: begin w = 13'd0;    h = 13'h1FFF; end
                1: begin w = 13'h1FFF; h = 13'd0;    end
                2: begin w = 13'd1;    h = 13'd1;    end
                3: begin w = 13'd4096; h = 13'd4096; end
                4: begin w = SCREEN_WIDTH_RST; h = SCREEN_HEIGHT_RST; end
                default: begin w = pick_size(); h = pick_size(); end
            endcase
            if (p < 5 || $urandom_range(0, 3) != 0)
                write_reg(REG_SCREEN_WIDTH, w);
            if (p < 5 || $urandom_range(0, 3) != 0)
                write_reg(REG_SCREEN_HEIGHT, h);
            if ($urandom_range(0, 2) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          SIZE_W'($urandom_range(0, 8191)));
            steady_flow = (p % 4 == 3);
            sent = 0;
            while (sent < 90)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 2)
                begin
                    send_byte(BYTE_W'($urandom_range(0, 255)) & ~HDR_SYNC_MASK);
                    sent += 1;
                end
                else if (pick == 2)
                begin
                    send_byte(BYTE_W'($urandom_range(0, 255)) | HDR_SYNC_MASK);
                    send_byte(pick_move());
                    sent += 2;
                end
                else
                begin
                    send_packet(BYTE_W'($urandom_range(0, 255)) | HDR_SYNC_MASK,
                                pick_move(), pick_move());
                    sent += 3;
                end
            end
            settle_idle();
            steady_flow = 1'b0;
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_packets();
        test_screen_extremes();
        test_spare_indexes();
        test_random_traffic();
        settle_idle();
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
